// File: design/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Types and codes shared by the S-record loader modules.
// ----------------------------------------------------------------------------
package srl_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_S     = 3'd1,
        ERR_S1_SHORT = 3'd2,
        ERR_S9_AGAIN = 3'd3,
        ERR_S9_SHORT = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        REC_OTHER = 2'd0,
        REC_S1    = 2'd1,
        REC_S9    = 2'd2
    } rec_t;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] text_char;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic        start_valid;
        err_t        error_code;
        logic [15:0] line_number;
    } out_item_t;

    // classified character as it travels from front to back
    typedef struct packed {
        logic       eoi;
        logic       newline;
        logic       is_s;
        logic       is_one;
        logic       is_nine;
        logic [3:0] nib;
    } cls_t;

endpackage

// File: design/srl_front.sv
// ----------------------------------------------------------------------------
// srl_front
// Classifies each incoming item: end of input, newline, record letters and
// the hex value of the character.
// ----------------------------------------------------------------------------
module srl_front
    import srl_pkg::*;
(
    input  in_item_t item,
    output cls_t     cls
);

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_9  = 8'h39;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    always_comb
    begin
        cls.eoi     = (item.action == ACT_END);
        cls.newline = (item.text_char == CH_NL);
        cls.is_s    = (item.text_char == CH_S);
        cls.is_one  = (item.text_char == CH_1);
        cls.is_nine = (item.text_char == CH_9);
        cls.nib     = hex_value(item.text_char);
    end

endmodule

// File: design/srl_queue.sv
// ----------------------------------------------------------------------------
// srl_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module srl_queue
    import srl_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_item,
    output logic full,
    input  logic pop,
    output cls_t pop_item,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cls_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: design/srl_back.sv
// ----------------------------------------------------------------------------
// srl_back
// Line parser: tracks the position within a line, collects count, address
// and data digits, checks each line at its end and drives the result register.
// ----------------------------------------------------------------------------
module srl_back
    import srl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        q_empty,
    input  cls_t        q_item,
    output logic        q_pop,
    output logic        out_valid,
    output out_item_t   out_data,
    input  logic        out_stall
);

    localparam logic [9:0] POS_MAX = 10'd1023;

    logic [15:0] offset_reg;
    logic [9:0]  pos_reg,   pos_next;
    rec_t        rec_reg,   rec_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg,  addr_next;
    logic [3:0]  hi_reg,    hi_next;
    logic        seen_reg,  seen_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] line_reg,  line_next;
    logic        failed_reg, failed_next;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        res_valid;
    out_item_t   res_item;

    // line close checks
    logic [7:0]  cnt_eff;
    logic [10:0] line_len;
    logic [10:0] need_len;
    logic [15:0] s9_addr;
    err_t        close_err;
    logic [8:0]  byte_idx;
    logic [15:0] wr_addr;
    logic        do_close;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign q_pop     = !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cnt_eff  = (!q_item.eoi && pos_reg == 10'd3) ? {hi_reg, 4'd0} : count_reg;
        line_len = q_item.eoi ? {1'b0, pos_reg} : {1'b0, pos_reg} + 11'd1;
        need_len = 11'd4 + {2'b00, cnt_eff, 1'b0};
        s9_addr  = (!q_item.eoi && pos_reg == 10'd7) ? {addr_reg[11:0], 4'd0}
                                                    : addr_reg;
        close_err = ERR_NONE;
        unique case (rec_reg)
            REC_S1:
            begin
                if (line_len < need_len)
                    close_err = ERR_S1_SHORT;
            end
            REC_S9:
            begin
                if (seen_reg)
                    close_err = ERR_S9_AGAIN;
                else if (line_len < 11'd8)
                    close_err = ERR_S9_SHORT;
            end
            default: close_err = ERR_NONE;
        endcase
        byte_idx = 9'((pos_reg - 10'd9) >> 1);
        wr_addr  = offset_reg + addr_reg + {7'd0, byte_idx};
    end

    always_comb
    begin
        pos_next    = pos_reg;
        rec_next    = rec_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        hi_next     = hi_reg;
        seen_next   = seen_reg;
        start_next  = start_reg;
        line_next   = line_reg;
        failed_next = failed_reg;
        res_valid   = 1'b0;
        res_item    = '0;
        do_close    = 1'b0;

        if (q_pop && !failed_reg)
        begin
            if (q_item.eoi || (pos_reg != '0 && q_item.newline))
            begin
                // end of a line: by newline or by end of input
                do_close = q_item.eoi ? (pos_reg != '0) : 1'b1;
                pos_next   = '0;
                rec_next   = REC_OTHER;
                count_next = '0;
                addr_next  = '0;
                hi_next    = '0;
                if (do_close && close_err != ERR_NONE)
                begin
                    failed_next          = 1'b1;
                    res_valid            = 1'b1;
                    res_item.kind        = KIND_ERROR;
                    res_item.error_code  = close_err;
                    res_item.line_number = line_reg;
                end
                else
                begin
                    if (do_close)
                    begin
                        if (rec_reg == REC_S9)
                        begin
                            seen_next  = 1'b1;
                            start_next = s9_addr;
                        end
                        if (line_reg != 16'hFFFF)
                            line_next = line_reg + 16'd1;
                    end
                    if (q_item.eoi)
                    begin
                        res_valid = 1'b1;
                        res_item.kind = KIND_DONE;
                        if (do_close && rec_reg == REC_S9)
                        begin
                            res_item.address     = s9_addr;
                            res_item.start_valid = 1'b1;
                        end
                        else if (seen_reg)
                        begin
                            res_item.address     = start_reg;
                            res_item.start_valid = 1'b1;
                        end
                    end
                end
            end
            else if (pos_reg == '0)
            begin
                rec_next   = REC_OTHER;
                count_next = '0;
                addr_next  = '0;
                hi_next    = '0;
                if (!q_item.is_s)
                begin
                    failed_next          = 1'b1;
                    res_valid            = 1'b1;
                    res_item.kind        = KIND_ERROR;
                    res_item.error_code  = ERR_NO_S;
                    res_item.line_number = line_reg;
                end
                else
                    pos_next = 10'd1;
            end
            else
            begin
                priority if (pos_reg == 10'd1)
                    rec_next = q_item.is_one ? REC_S1 : (q_item.is_nine ? REC_S9 : REC_OTHER);
                else if (pos_reg == 10'd2)
                    hi_next = q_item.nib;
                else if (pos_reg == 10'd3)
                    count_next = {hi_reg, q_item.nib};
                else if (pos_reg <= 10'd7)
                    addr_next = {addr_reg[11:0], q_item.nib};
                else if (!pos_reg[0])
                    hi_next = q_item.nib;
                else if (rec_reg == REC_S1 && count_reg >= 8'd3)
                begin
                    if (byte_idx < {1'b0, count_reg - 8'd3})
                    begin
                        res_valid        = 1'b1;
                        res_item.kind    = KIND_WRITE;
                        res_item.address = wr_addr;
                        res_item.data    = {hi_reg, q_item.nib};
                    end
                end
                if (pos_reg < POS_MAX)
                    pos_next = pos_reg + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            pos_reg       <= '0;
            rec_reg       <= REC_OTHER;
            count_reg     <= '0;
            addr_reg      <= '0;
            hi_reg        <= '0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            line_reg      <= 16'd1;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                offset_reg <= cfg_wdata;
            pos_reg    <= pos_next;
            rec_reg    <= rec_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            hi_reg     <= hi_next;
            seen_reg   <= seen_next;
            start_reg  <= start_next;
            line_reg   <= line_next;
            failed_reg <= failed_next;
            if (res_valid)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_item_reg <= res_item;
    end

endmodule

// File: design/srecord_loader.sv
// ----------------------------------------------------------------------------
// srecord_loader
// Streaming S1/S9 record loader with a decoupled classifier and parser.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) takes one item per cycle while
// in_stall is low: a text character or an end-of-input marker. The output channel
// (out_valid, out_stall, out_data) gives at most one result per item: a memory write for
// each data byte of an S1 line, success at end of input (with the start address once
// an S9 line has given one), or an error, after which the block is silent until reset.
// The front classifies each item and pushes it into a queue of QUEUE_DEPTH
// entries; the back pops one entry per cycle unless a pending result is stalled,
// and loads the output register. An accepted item waits in a queue slot before
// the back registers its result there.
// Throughput: one item per cycle while neither channel stalls.
// When the receiver stalls a pending result, the output register holds and the back stops
// popping; the queue keeps accepting until full, then in_stall is raised.
// cfg_we/cfg_wdata write the load offset; write it only while idle.
// Reset empties the queue, clears the line state and the load offset,
// forgets any start address and sets the line counter to one.
// ----------------------------------------------------------------------------
module srecord_loader
    import srl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    cls_t front_cls;
    cls_t q_item;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign in_stall = q_full;

    srl_front u_front
    (
        .item (in_data),
        .cls  (front_cls)
    );

    srl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    srl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

endmodule

// File: design/srl_checker.sv
// ----------------------------------------------------------------------------
// srl_checker
// Port-level checks for the S-record loader, bound to the top level.
// ----------------------------------------------------------------------------
module srl_checker
    import srl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // nothing follows an accepted error
    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.kind == KIND_ERROR |=> !out_valid)
        else $error("result after error");

    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_WRITE |->
            out_data.error_code == ERR_NONE && out_data.line_number == 16'd0
            && !out_data.start_valid)
        else $error("write item carries stray fields");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_ERROR |->
            out_data.error_code != ERR_NONE && out_data.address == 16'd0
            && out_data.line_number != 16'd0)
        else $error("malformed error item");

endmodule

bind srecord_loader srl_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
